FILE: design/assert_macros.svh
// Assertion macros shared by the checker module of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Same check, but also active while rst is high.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: design/wsfr_pkg.sv
// Shared types and codes of the WebSocket frame receiver.
// Depends on nothing; used by the parser, the output buffer and the top level.
package wsfr_pkg;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_MASK = 2'd1;
  localparam logic [1:0] ERR_TOO_BIG = 2'd2;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd131;
  localparam logic [6:0]  LEN7_EXT16       = 7'd126;
  localparam logic [6:0]  LEN7_EXT64       = 7'd127;

  typedef struct packed {
    logic [1:0] error_code;
    logic       last_of_frame;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic       has_data;
    logic [7:0] out_byte;
  } wsfr_result_t;

endpackage

FILE: design/wsfr_parser.sv
// Frame parser: header, extended length, mask key and payload unmasking.
// Depends on wsfr_pkg. Produces at most one result for each accepted byte.
module wsfr_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_data,
  input  logic                  in_accept,
  input  logic [7:0]            in_byte,
  output logic                  res_valid,
  output wsfr_pkg::wsfr_result_t res
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] max_payload;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        fin_reg, fin_reg_next;
  logic [15:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] byte_counter, byte_counter_next;

  logic [15:0] len_full;
  logic [16:0] count_inc;
  logic [7:0]  key;
  logic        last;

  always_comb begin
    phase_next          = phase;
    opcode_reg_next     = opcode_reg;
    fin_reg_next        = fin_reg;
    payload_length_next = payload_length;
    mask_key_next       = mask_key;
    byte_counter_next   = byte_counter;
    res_valid           = 1'b0;
    res.out_byte        = 8'h00;
    res.has_data        = 1'b0;
    res.frame_opcode    = opcode_reg;
    res.fin_flag        = fin_reg;
    res.last_of_frame   = 1'b0;
    res.error_code      = wsfr_pkg::ERR_NONE;
    len_full            = {payload_length[15:8], in_byte};
    count_inc           = {1'b0, byte_counter} + 17'd1;
    last                = (count_inc >= {1'b0, payload_length});
    case (byte_counter[1:0])
      2'd0:    key = mask_key[31:24];
      2'd1:    key = mask_key[23:16];
      2'd2:    key = mask_key[15:8];
      default: key = mask_key[7:0];
    endcase
    if (in_accept) begin
      unique case (phase)
        PH_HDR0: begin
          opcode_reg_next = in_byte[3:0];
          fin_reg_next    = in_byte[7];
          phase_next      = PH_HDR1;
        end
        PH_HDR1: begin
          if (!in_byte[7]) begin
            res_valid      = 1'b1;
            res.error_code = wsfr_pkg::ERR_NO_MASK;
            phase_next     = PH_ERROR;
          end else if (in_byte[6:0] == wsfr_pkg::LEN7_EXT64) begin
            res_valid      = 1'b1;
            res.error_code = wsfr_pkg::ERR_TOO_BIG;
            phase_next     = PH_ERROR;
          end else begin
            payload_length_next = {9'd0, in_byte[6:0]};
            byte_counter_next   = 16'd0;
            mask_key_next       = 32'd0;
            phase_next = (in_byte[6:0] == wsfr_pkg::LEN7_EXT16) ? PH_LEN_HI : PH_MASK;
          end
        end
        PH_LEN_HI: begin
          payload_length_next = {in_byte, 8'h00};
          phase_next          = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          payload_length_next = len_full;
          if (len_full > max_payload) begin
            res_valid      = 1'b1;
            res.error_code = wsfr_pkg::ERR_TOO_BIG;
            phase_next     = PH_ERROR;
          end else begin
            byte_counter_next = 16'd0;
            phase_next        = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (count_inc < 17'd4) begin
            byte_counter_next = count_inc[15:0];
          end else begin
            byte_counter_next = 16'd0;
            if (payload_length == 16'd0) begin
              res_valid         = 1'b1;
              res.last_of_frame = 1'b1;
              phase_next        = PH_HDR0;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.out_byte      = in_byte ^ key;
          res.has_data      = 1'b1;
          res.last_of_frame = last;
          if (last) begin
            byte_counter_next = 16'd0;
            phase_next        = PH_HDR0;
          end else begin
            byte_counter_next = count_inc[15:0];
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      max_payload    <= wsfr_pkg::MAX_PAYLOAD_RESET;
      opcode_reg     <= 4'd0;
      fin_reg        <= 1'b0;
      payload_length <= 16'd0;
      mask_key       <= 32'd0;
      byte_counter   <= 16'd0;
    end else begin
      phase          <= phase_next;
      opcode_reg     <= opcode_reg_next;
      fin_reg        <= fin_reg_next;
      payload_length <= payload_length_next;
      mask_key       <= mask_key_next;
      byte_counter   <= byte_counter_next;
      if (cfg_we) begin
        max_payload <= cfg_data;
      end
    end
  end

endmodule

FILE: design/wsfr_out_buf.sv
// Two-entry output buffer that holds results while the receiver stalls.
// Depends on wsfr_pkg for the result type.
module wsfr_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wsfr_pkg::wsfr_result_t din,
  output logic                  ready,
  output logic                  valid,
  input  logic                  pop_ready,
  output wsfr_pkg::wsfr_result_t dout
);

  wsfr_pkg::wsfr_result_t entry0, entry1;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign ready = (count != 2'd2);
  assign pop   = valid && pop_ready;
  assign dout  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry0 <= (push && count == 2'd1) ? din : entry1;
      if (push && count == 2'd2) begin
        entry1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= din;
      end else begin
        entry1 <= din;
      end
    end
  end

endmodule

FILE: design/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: stream ports around the parser
// and the output buffer. Depends on wsfr_pkg, wsfr_parser and wsfr_out_buf.
//
// The slave channel takes the raw client-to-server byte stream, one byte per
// item. Header, length and mask bytes produce no result; each payload byte
// produces one unmasked result, and a zero-length frame produces one empty
// result marked with tlast. A protocol error produces one error result, after
// which input is still accepted but ignored until reset.
// Throughput is one byte per cycle while the output buffer has room. Each result
// is registered in the output buffer before it appears on the master channel.
// A two-entry output buffer lets input continue while the receiver stalls;
// s_axis_tready drops only when both entries are full.
// Reset (rst, synchronous) returns the parser to the first header byte and
// max_payload to 131, and empties the buffer. The user must write max_payload
// via cfg_we and cfg_data only while no frame is in progress; it is not enforced.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,      // max_payload
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [7:0]  m_axis_tuser,  // [0] has_data, [4:1] frame_opcode, [5] fin_flag,
                                     // [7:6] error_code
  output logic        m_axis_tlast   // last_of_frame
);

  logic                   in_accept;
  logic                   res_valid;
  wsfr_pkg::wsfr_result_t res;
  wsfr_pkg::wsfr_result_t head;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  wsfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .ready     (s_axis_tready),
    .valid     (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .dout      (head)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.error_code, head.fin_flag, head.frame_opcode, head.has_data};
  assign m_axis_tlast = head.last_of_frame;

endmodule

FILE: design/wsfr_checker.sv
// Port-level checks of the WebSocket frame receiver, bound to the top level.
// Depends on assert_macros.svh, wsfr_pkg and websocket_frame_receiver.
`include "assert_macros.svh"

module wsfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic is_error;

  assign is_error = (m_axis_tuser[7:6] != wsfr_pkg::ERR_NONE);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_CLK(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
  `ASSERT_CLK(a_err_plain, m_axis_tvalid && is_error |-> !m_axis_tlast && !m_axis_tuser[0])
  `ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid && s_axis_tready)

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for websocket_frame_receiver: sends masked frames byte by byte
// and compares every result with a cycle-free predictor of the deframer. Depends on wsfr_pkg
// and the websocket_frame_receiver RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES_PER_PHASE = 300;

  typedef enum logic [2:0] {
    ST_HEADER0,
    ST_HEADER1,
    ST_EXTLEN_HI,
    ST_EXTLEN_LO,
    ST_MASK,
    ST_PAYLOAD,
    ST_HALTED
  } deframe_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state, kept in step with the accepted input bytes.
  deframe_phase_t phase_m = ST_HEADER0;
  logic [3:0]     opcode_m = '0;
  logic           fin_m = 1'b0;
  logic [15:0]    length_m = '0;
  logic [31:0]    key_m = '0;
  logic [15:0]    count_m = '0;
  logic [15:0]    max_len_m = wsfr_pkg::MAX_PAYLOAD_RESET;

  wsfr_pkg::wsfr_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  idle_cycles = 0;
  bit           tx_no_gaps = 1'b0;
  bit           rx_no_stall = 1'b0;
  int unsigned  rx_hold_req = 0;
  int unsigned  rx_hold_left = 0;

  websocket_frame_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic bit deframe_byte(input logic [7:0] b, output wsfr_pkg::wsfr_result_t r);
    bit          emit;
    logic [16:0] next_count;
    logic [31:0] shifted;
    emit = 1'b0;
    r = '0;
    case (phase_m)
      ST_HEADER0: begin
        opcode_m = b[3:0];
        fin_m = b[7];
        phase_m = ST_HEADER1;
      end
      ST_HEADER1: begin
        if (!b[7]) begin
          phase_m = ST_HALTED;
          r.error_code = wsfr_pkg::ERR_NO_MASK;
          emit = 1'b1;
        end else if (b[6:0] == wsfr_pkg::LEN7_EXT64) begin
          phase_m = ST_HALTED;
          r.error_code = wsfr_pkg::ERR_TOO_BIG;
          emit = 1'b1;
        end else begin
          length_m = {9'd0, b[6:0]};
          count_m = '0;
          key_m = '0;
          phase_m = (b[6:0] == wsfr_pkg::LEN7_EXT16) ? ST_EXTLEN_HI : ST_MASK;
        end
      end
      ST_EXTLEN_HI: begin
        length_m = {b, 8'h00};
        phase_m = ST_EXTLEN_LO;
      end
      ST_EXTLEN_LO: begin
        length_m[7:0] = b;
        if (length_m > max_len_m) begin
          phase_m = ST_HALTED;
          r.error_code = wsfr_pkg::ERR_TOO_BIG;
          emit = 1'b1;
        end else begin
          count_m = '0;
          phase_m = ST_MASK;
        end
      end
      ST_MASK: begin
        key_m = {key_m[23:0], b};
        count_m = count_m + 16'd1;
        if (count_m == 16'd4) begin
          count_m = '0;
          if (length_m == 16'd0) begin
            phase_m = ST_HEADER0;
            r.last_of_frame = 1'b1;
            emit = 1'b1;
          end else begin
            phase_m = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        shifted = key_m >> (24 - 8 * count_m[1:0]);
        next_count = {1'b0, count_m} + 17'd1;
        r.out_byte = b ^ shifted[7:0];
        r.has_data = 1'b1;
        r.last_of_frame = (next_count >= {1'b0, length_m});
        count_m = next_count[15:0];
        if (r.last_of_frame) begin
          phase_m = ST_HEADER0;
          count_m = '0;
        end
        emit = 1'b1;
      end
      default: ;
    endcase
    r.frame_opcode = opcode_m;
    r.fin_flag = fin_m;
    return emit;
  endfunction

  // Receiver side: random stalls, optional stall-free stretch, and requested hold-offs.
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_no_stall) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin : monitor
    wsfr_pkg::wsfr_result_t exp_r;
    wsfr_pkg::wsfr_result_t got;
    bit           moved;
    moved = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      moved = 1'b1;
      if (deframe_byte(s_axis_tdata, exp_r)) pending_results.push_back(exp_r);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      got.out_byte = m_axis_tdata;
      got.has_data = m_axis_tuser[0];
      got.frame_opcode = m_axis_tuser[4:1];
      got.fin_flag = m_axis_tuser[5];
      got.error_code = m_axis_tuser[7:6];
      got.last_of_frame = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $error("unexpected result: %h", got);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.out_byte !== exp_r.out_byte) begin
          $error("out_byte: expected %0h, got %0h", exp_r.out_byte, got.out_byte);
          mismatch_count++;
        end
        if (got.has_data !== exp_r.has_data) begin
          $error("has_data: expected %0h, got %0h", exp_r.has_data, got.has_data);
          mismatch_count++;
        end
        if (got.frame_opcode !== exp_r.frame_opcode) begin
          $error("frame_opcode: expected %0h, got %0h", exp_r.frame_opcode, got.frame_opcode);
          mismatch_count++;
        end
        if (got.fin_flag !== exp_r.fin_flag) begin
          $error("fin_flag: expected %0h, got %0h", exp_r.fin_flag, got.fin_flag);
          mismatch_count++;
        end
        if (got.last_of_frame !== exp_r.last_of_frame) begin
          $error("last_of_frame: expected %0h, got %0h", exp_r.last_of_frame,
                 got.last_of_frame);
          mismatch_count++;
        end
        if (got.error_code !== exp_r.error_code) begin
          $error("error_code: expected %0h, got %0h", exp_r.error_code, got.error_code);
          mismatch_count++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!tx_no_gaps && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // The first edge lets the monitor record the last accepted byte before the queue is read.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_m = value;
  endtask

  // A negative fill gives random payload bytes.
  task automatic send_frame(input logic [7:0] hdr0, input int unsigned len, input bit ext_form,
                            input logic [31:0] key, input int fill);
    logic [15:0] len16;
    len16 = len[15:0];
    send_byte(hdr0);
    if (ext_form || len > 125) begin
      send_byte({1'b1, wsfr_pkg::LEN7_EXT16});
      send_byte(len16[15:8]);
      send_byte(len16[7:0]);
    end else begin
      send_byte({1'b1, len16[6:0]});
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++)
      send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic test_directed_frames();
    send_frame(8'h81, 0, 1'b0, 32'h0000_0000, 0);
    send_frame(8'h0F, 1, 1'b0, 32'hFFFF_FFFF, 255);
    send_frame(8'hF0, 4, 1'b1, 32'hA55A_0FF0, 0);
    wait_idle();
  endtask

  task automatic test_length_limits();
    set_max_payload(16'd0);
    send_frame(8'h82, 0, 1'b1, $urandom, -1);
    // A 7-bit length is never compared with the limit.
    send_frame(8'h02, 100, 1'b0, $urandom, -1);
    set_max_payload(wsfr_pkg::MAX_PAYLOAD_RESET);
    send_frame(8'h81, 131, 1'b1, $urandom, -1);
    send_frame(8'h09, 5, 1'b1, $urandom, -1);
    set_max_payload(16'hFFFF);
    tx_no_gaps = 1'b1;
    rx_no_stall = 1'b1;
    send_frame(8'h82, 256, 1'b1, $urandom, -1);
    tx_no_gaps = 1'b0;
    rx_no_stall = 1'b0;
    wait_idle();
  endtask

  task automatic test_backpressure();
    rx_hold_req = 120;
    tx_no_gaps = 1'b1;
    send_frame(8'h82, 50, 1'b0, $urandom, -1);
    tx_no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned len;
    int unsigned cap;
    int unsigned pick;
    bit          ext_form;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: set_max_payload(16'($urandom_range(126, 400)));
        1: set_max_payload(16'($urandom));
        default: set_max_payload(16'($urandom_range(0, 125)));
      endcase
      cap = (max_len_m < 300) ? max_len_m : 300;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        ext_form = 1'b0;
        if (pick < 55) begin
          len = $urandom_range(1, 12);
        end else if (pick < 70) begin
          len = 0;
        end else if (pick < 85) begin
          len = $urandom_range(13, 125);
        end else begin
          ext_form = 1'b1;
          len = $urandom_range(0, cap);
        end
        send_frame(8'($urandom), len, ext_form, $urandom, -1);
      end
      wait_idle();
    end
  endtask

  // Only one protocol error can be seen per reset, so the kind is chosen at random.
  task automatic test_protocol_error();
    logic [15:0] limit;
    logic [15:0] too_long;
    send_byte(8'($urandom));
    case ($urandom_range(0, 3))
      0: send_byte({1'b0, wsfr_pkg::LEN7_EXT64});
      1: send_byte({1'b0, 7'($urandom)});
      2: send_byte({1'b1, wsfr_pkg::LEN7_EXT64});
      default: begin
        limit = max_len_m;
        too_long = (limit == 16'hFFFF) ? limit : 16'($urandom_range(limit + 1, 65535));
        send_byte({1'b1, wsfr_pkg::LEN7_EXT16});
        send_byte(too_long[15:8]);
        send_byte(too_long[7:0]);
      end
    endcase
    repeat (40) send_byte(8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_length_limits();
    test_backpressure();
    test_random_frames();
    set_max_payload(16'($urandom_range(0, 65534)));
    test_protocol_error();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
